FILE: hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types, widths, codes and the multiply schedule of the triangle
// tangent and binormal block.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int DEF_VERTEX_DEPTH = 1024;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 10;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int Q_W       = 32;
    localparam int NUM_LANES = 6;
    localparam int RES_CNT   = NUM_LANES + 1;
    localparam int RES_W     = $clog2(RES_CNT);
    localparam int RES_DET   = 0;
    localparam int MUL_STEPS = 2 * RES_CNT;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TRI  = 1'b1;

    typedef logic signed [DATA_W-1:0] ttb_data_t;
    typedef logic signed [DIFF_W-1:0] ttb_diff_t;
    typedef logic signed [PROD_W-1:0] ttb_prod_t;
    typedef logic signed [NUM_W-1:0]  ttb_num_t;
    typedef logic signed [Q_W-1:0]    ttb_quo_t;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] vert_slot;
        ttb_data_t        pos_x;
        ttb_data_t        pos_y;
        ttb_data_t        pos_z;
        ttb_data_t        tex_u;
        ttb_data_t        tex_v;
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
    } ttb_in_t;

    typedef struct packed {
        ttb_quo_t tangent_x;
        ttb_quo_t tangent_y;
        ttb_quo_t tangent_z;
        ttb_quo_t binormal_x;
        ttb_quo_t binormal_y;
        ttb_quo_t binormal_z;
        logic     degenerate;
    } ttb_out_t;

    typedef struct packed {
        ttb_data_t pos_x;
        ttb_data_t pos_y;
        ttb_data_t pos_z;
        ttb_data_t tex_u;
        ttb_data_t tex_v;
    } ttb_vert_t;

    typedef struct packed {
        ttb_diff_t e1x;
        ttb_diff_t e1y;
        ttb_diff_t e1z;
        ttb_diff_t e2x;
        ttb_diff_t e2y;
        ttb_diff_t e2z;
        ttb_diff_t du1;
        ttb_diff_t dv1;
        ttb_diff_t du2;
        ttb_diff_t dv2;
    } ttb_diffs_t;

    typedef enum logic [3:0] {
        OPD_E1X, OPD_E1Y, OPD_E1Z,
        OPD_E2X, OPD_E2Y, OPD_E2Z,
        OPD_DU1, OPD_DV1, OPD_DU2, OPD_DV2
    } ttb_opd_t;

    typedef struct packed {
        ttb_opd_t a;
        ttb_opd_t b;
    } ttb_mop_t;

    // Each result takes two steps: the first product is loaded, the second
    // is subtracted. Results are the determinant, tangent xyz, binormal xyz.
    function automatic ttb_mop_t ttb_mul_op(logic [MUL_CNT_W-1:0] step);
        ttb_mop_t m;
        case (step)
            4'd0:    m = '{a: OPD_DU1, b: OPD_DV2};
            4'd1:    m = '{a: OPD_DU2, b: OPD_DV1};
            4'd2:    m = '{a: OPD_DV2, b: OPD_E1X};
            4'd3:    m = '{a: OPD_DV1, b: OPD_E2X};
            4'd4:    m = '{a: OPD_DV2, b: OPD_E1Y};
            4'd5:    m = '{a: OPD_DV1, b: OPD_E2Y};
            4'd6:    m = '{a: OPD_DV2, b: OPD_E1Z};
            4'd7:    m = '{a: OPD_DV1, b: OPD_E2Z};
            4'd8:    m = '{a: OPD_DU1, b: OPD_E2X};
            4'd9:    m = '{a: OPD_DU2, b: OPD_E1X};
            4'd10:   m = '{a: OPD_DU1, b: OPD_E2Y};
            4'd11:   m = '{a: OPD_DU2, b: OPD_E1Y};
            4'd12:   m = '{a: OPD_DU1, b: OPD_E2Z};
            4'd13:   m = '{a: OPD_DU2, b: OPD_E1Z};
            default: m = '{a: OPD_DU1, b: OPD_DV2};
        endcase
        return m;
    endfunction

    function automatic ttb_diff_t ttb_pick(ttb_opd_t s, ttb_diffs_t d);
        ttb_diff_t v;
        case (s)
            OPD_E1X: v = d.e1x;
            OPD_E1Y: v = d.e1y;
            OPD_E1Z: v = d.e1z;
            OPD_E2X: v = d.e2x;
            OPD_E2Y: v = d.e2y;
            OPD_E2Z: v = d.e2z;
            OPD_DU1: v = d.du1;
            OPD_DV1: v = d.dv1;
            OPD_DU2: v = d.du2;
            OPD_DV2: v = d.dv2;
            default: v = d.du1;
        endcase
        return v;
    endfunction

    function automatic ttb_diff_t ttb_sub(ttb_data_t x, ttb_data_t y);
        return DIFF_W'(x) - DIFF_W'(y);
    endfunction

endpackage

FILE: hw/rtl/ttb_stream_if.sv
// ----------------------------------------------------------------------------
// ttb_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ttb_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hw/rtl/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div
// Six-lane restoring divider sharing one divisor. Gives each numerator
// times 2^FRAC_BITS over the divisor, rounded half away from zero and
// saturated to 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttb_div
    import ttb_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ttb_num_t det,
    input  ttb_num_t num [NUM_LANES],
    output logic     done,
    output ttb_quo_t quo [NUM_LANES]
);

    localparam int MAG_W = NUM_W;
    localparam int DW    = MAG_W + Q_W;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);
    localparam logic [Q_W:0] LIM_POS = (Q_W + 1)'((65'd1 << (Q_W - 1)) - 65'd1);
    localparam logic [Q_W:0] LIM_NEG = (Q_W + 1)'(65'd1 << (Q_W - 1));

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_PRE  = 5'b00010,
        D_ITER = 5'b00100,
        D_RND  = 5'b01000,
        D_FIN  = 5'b10000
    } dstate_t;

    dstate_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [MAG_W-1:0] dmag_reg;
    logic [DW-1:0]    dsh_reg;
    logic [DW-1:0]    rem_reg [NUM_LANES];
    logic [Q_W-1:0]   q_reg   [NUM_LANES];
    logic [Q_W:0]     qr_reg  [NUM_LANES];
    logic             sat_reg [NUM_LANES];
    logic             neg_reg [NUM_LANES];
    ttb_quo_t         quo_reg [NUM_LANES];

    logic [MAG_W-1:0] dmag;
    logic             ge      [NUM_LANES];
    logic [Q_W:0]     lim     [NUM_LANES];
    logic [Q_W:0]     mclip   [NUM_LANES];
    logic [Q_W:0]     mneg    [NUM_LANES];

    assign dmag = det[NUM_W-1] ? MAG_W'(-det) : MAG_W'(det);

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            ge[l]    = rem_reg[l] >= dsh_reg;
            lim[l]   = neg_reg[l] ? LIM_NEG : LIM_POS;
            mclip[l] = (sat_reg[l] || qr_reg[l] > lim[l]) ? lim[l] : qr_reg[l];
            mneg[l]  = (Q_W + 1)'(0) - mclip[l];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = D_PRE;
            D_PRE:   state_next = D_ITER;
            D_ITER:  if (cnt_reg == CNT_LAST) state_next = D_RND;
            D_RND:   state_next = D_FIN;
            D_FIN:   state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_FIN);
            if (state_reg == D_PRE)
                cnt_reg <= '0;
            else if (state_reg == D_ITER)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    dmag_reg <= dmag;
                    dsh_reg  <= DW'(dmag) << Q_W;
                    for (int l = 0; l < NUM_LANES; l++)
                    begin
                        rem_reg[l] <= DW'(num[l][NUM_W-1] ? MAG_W'(-num[l])
                                                          : MAG_W'(num[l])) << FRAC_BITS;
                        neg_reg[l] <= num[l][NUM_W-1] ^ det[NUM_W-1];
                    end
                end
            end
            D_PRE:
            begin
                // A quotient of 2^32 or more saturates whatever its sign.
                for (int l = 0; l < NUM_LANES; l++)
                    sat_reg[l] <= ge[l];
                dsh_reg <= dsh_reg >> 1;
            end
            D_ITER:
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    if (ge[l])
                        rem_reg[l] <= rem_reg[l] - dsh_reg;
                    q_reg[l] <= {q_reg[l][Q_W-2:0], ge[l]};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            D_RND:
            begin
                for (int l = 0; l < NUM_LANES; l++)
                    qr_reg[l] <= (Q_W + 1)'(q_reg[l])
                               + (Q_W + 1)'({rem_reg[l], 1'b0} >= (DW + 1)'(dmag_reg));
            end
            D_FIN:
            begin
                for (int l = 0; l < NUM_LANES; l++)
                    quo_reg[l] <= neg_reg[l] ? mneg[l][Q_W-1:0] : mclip[l][Q_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: hw/rtl/triangle_tangent_binormal_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_top
// Vertex store plus tangent and binormal computation for mesh triangles.
// ----------------------------------------------------------------------------
// A load item (func 0) writes one vertex into the store in the cycle it is
// accepted and gives no result. A triangle item (func 1) is accepted only
// while the block is idle and gives one result: the three corners are read
// through the store's single read port, the one shared 33x33 multiplier
// forms the determinant and the six numerators, the divider produces one
// quotient bit per cycle for all six components at once, and the output
// register is loaded once any earlier result has been taken. A degenerate
// triangle skips the divider. The finished result sits in an output
// register, so new items are taken while it waits.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_top
    import ttb_pkg::*;
#(
    parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    ttb_stream_if.sink   cmd,
    ttb_stream_if.source vec
);

    localparam int ADDR_W = $clog2(VERTEX_DEPTH);
    localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
    localparam logic [1:0] FETCH_LAST = 2'd3;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_MUL    = 6'b000100,
        S_DSTART = 6'b001000,
        S_DWAIT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           fetch_cnt_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    logic                 out_valid_reg;

    ttb_vert_t        store_mem [VERTEX_DEPTH];
    ttb_vert_t        rd_vert_reg;
    logic             rd_ok_reg;
    ttb_vert_t        vert_a_reg;
    logic [IDX_W-1:0] crn_a_reg, crn_b_reg, crn_c_reg;
    ttb_diffs_t       diffs_reg;
    ttb_prod_t        prod_reg;
    ttb_prod_t        acc_reg;
    ttb_num_t         res_reg [RES_CNT];
    logic             degen_reg;
    ttb_out_t         out_data_reg;

    ttb_in_t              in_item;
    logic                 cmd_acc;
    logic                 load_wr;
    logic [IDX_W-1:0]     rd_idx;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_ok;
    ttb_vert_t            vert_rd;
    ttb_mop_t             mop;
    ttb_diff_t            mul_a, mul_b;
    logic [MUL_CNT_W-1:0] prev_step;
    logic                 det_zero;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    ttb_num_t             div_num [NUM_LANES];
    ttb_quo_t             div_quo [NUM_LANES];

    assign in_item   = cmd.data;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign load_wr   = cmd_acc && (in_item.func == FUNC_LOAD)
                       && (CMP_W'(in_item.vert_slot) < CMP_W'(VERTEX_DEPTH));

    always_comb
    begin
        case (fetch_cnt_reg)
            2'd0:    rd_idx = crn_a_reg;
            2'd1:    rd_idx = crn_b_reg;
            default: rd_idx = crn_c_reg;
        endcase
    end

    assign rd_addr = ADDR_W'(rd_idx);
    assign rd_ok   = CMP_W'(rd_idx) < CMP_W'(VERTEX_DEPTH);
    // A corner beyond the store reads as an all-zero vertex.
    assign vert_rd = rd_ok_reg ? rd_vert_reg : '0;

    assign mop       = ttb_mul_op(mul_cnt_reg);
    assign mul_a     = ttb_pick(mop.a, diffs_reg);
    assign mul_b     = ttb_pick(mop.b, diffs_reg);
    assign prev_step = mul_cnt_reg - MUL_CNT_W'(1);
    assign det_zero  = (res_reg[RES_DET] == '0);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || vec.ready);
    assign div_start = (state_reg == S_DSTART);

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
            div_num[l] = res_reg[l + 1];
    end

    ttb_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .det   (res_reg[RES_DET]),
        .num   (div_num),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (cmd_acc && in_item.func == FUNC_TRI)
                    state_next = S_FETCH;
            S_FETCH:
                if (fetch_cnt_reg == FETCH_LAST)
                    state_next = S_MUL;
            S_MUL:
                if (mul_cnt_reg == MUL_LAST)
                    state_next = det_zero ? S_DONE : S_DSTART;
            S_DSTART:
                state_next = S_DWAIT;
            S_DWAIT:
                if (div_done)
                    state_next = S_DONE;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fetch_cnt_reg <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
                fetch_cnt_reg <= '0;
            else if (state_reg == S_FETCH)
                fetch_cnt_reg <= fetch_cnt_reg + 2'd1;
            if (state_reg == S_FETCH)
                mul_cnt_reg <= '0;
            else if (state_reg == S_MUL)
                mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (vec.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
            store_mem[ADDR_W'(in_item.vert_slot)] <= '{
                pos_x: in_item.pos_x,
                pos_y: in_item.pos_y,
                pos_z: in_item.pos_z,
                tex_u: in_item.tex_u,
                tex_v: in_item.tex_v
            };
        rd_vert_reg <= store_mem[rd_addr];
        rd_ok_reg   <= rd_ok;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            crn_a_reg <= in_item.corner_a;
            crn_b_reg <= in_item.corner_b;
            crn_c_reg <= in_item.corner_c;
        end

        if (state_reg == S_FETCH)
        begin
            case (fetch_cnt_reg)
                2'd1:
                    vert_a_reg <= vert_rd;
                2'd2:
                begin
                    diffs_reg.e1x <= ttb_sub(vert_rd.pos_x, vert_a_reg.pos_x);
                    diffs_reg.e1y <= ttb_sub(vert_rd.pos_y, vert_a_reg.pos_y);
                    diffs_reg.e1z <= ttb_sub(vert_rd.pos_z, vert_a_reg.pos_z);
                    diffs_reg.du1 <= ttb_sub(vert_rd.tex_u, vert_a_reg.tex_u);
                    diffs_reg.dv1 <= ttb_sub(vert_rd.tex_v, vert_a_reg.tex_v);
                end
                2'd3:
                begin
                    diffs_reg.e2x <= ttb_sub(vert_rd.pos_x, vert_a_reg.pos_x);
                    diffs_reg.e2y <= ttb_sub(vert_rd.pos_y, vert_a_reg.pos_y);
                    diffs_reg.e2z <= ttb_sub(vert_rd.pos_z, vert_a_reg.pos_z);
                    diffs_reg.du2 <= ttb_sub(vert_rd.tex_u, vert_a_reg.tex_u);
                    diffs_reg.dv2 <= ttb_sub(vert_rd.tex_v, vert_a_reg.tex_v);
                end
                default:
                begin
                end
            endcase
        end

        // The product of one step is folded in during the next: an even
        // step loads the accumulator, an odd step finishes a result.
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            if (mul_cnt_reg != '0)
            begin
                if (!prev_step[0])
                    acc_reg <= prod_reg;
                else
                    res_reg[prev_step[MUL_CNT_W-1:1]] <= NUM_W'(acc_reg) - NUM_W'(prod_reg);
            end
            if (mul_cnt_reg == MUL_LAST)
                degen_reg <= det_zero;
        end

        if (out_load)
        begin
            if (degen_reg)
                out_data_reg <= '{
                    tangent_x: '0, tangent_y: '0, tangent_z: '0,
                    binormal_x: '0, binormal_y: '0, binormal_z: '0,
                    degenerate: 1'b1
                };
            else
                out_data_reg <= '{
                    tangent_x: div_quo[0], tangent_y: div_quo[1], tangent_z: div_quo[2],
                    binormal_x: div_quo[3], binormal_y: div_quo[4], binormal_z: div_quo[5],
                    degenerate: 1'b0
                };
        end
    end

    assign vec.valid = out_valid_reg;
    assign vec.data  = out_data_reg;

    a_div_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside the wait state");

    a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result appeared without a finished triangle");

    a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (vec.valid && vec.data.degenerate) |->
            (vec.data.tangent_x == '0 && vec.data.tangent_y == '0
             && vec.data.tangent_z == '0 && vec.data.binormal_x == '0
             && vec.data.binormal_y == '0 && vec.data.binormal_z == '0))
        else $error("degenerate result carries nonzero vectors");

endmodule
